// File: sv/fsk_pkg.sv
`default_nettype none
package fsk_pkg;
    localparam int SYMBOL_SAMPLES = 160;
    localparam int DL_DEPTH = SYMBOL_SAMPLES + 1;
    localparam int DL_AW = $clog2(DL_DEPTH);
    localparam int FILL_W = $clog2(SYMBOL_SAMPLES + 1);

    localparam int SAMPLE_W = 16;
    localparam int X_W = SAMPLE_W + 1;
    localparam int COEF_W = 18;
    localparam int RES_W = 32;
    localparam int NRG_W = 48;
    localparam int OP_W = 32;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W = 56;
    localparam int HOLD_W = 6;
    localparam int NUM_REGS = 8;
    localparam int REG_AW = $clog2(NUM_REGS);
    localparam int PADDR_W = REG_AW + 2;

    localparam logic [HOLD_W-1:0] HOLD_RELOAD = 6'd50;
    localparam logic [NRG_W:0] HI_THRESH = 49'd3932160;
    localparam logic [NRG_W:0] LO_THRESH = 49'd3276800;

    localparam logic signed [OP_W-1:0] UNITY = 32'sd65536;
    localparam logic signed [OP_W-1:0] LP_B0 = 32'sd6293;
    localparam logic signed [OP_W-1:0] LP_B1 = 32'sd12585;
    localparam logic signed [OP_W-1:0] LP_A1 = 32'sd32623297;
    localparam logic signed [OP_W-1:0] LP_NA2 = -32'sd15871246;

    typedef enum logic [REG_AW-1:0] {
        REG_SPACE_RES_COS  = 3'd0,
        REG_SPACE_RES_SIN  = 3'd1,
        REG_SPACE_COMB_COS = 3'd2,
        REG_SPACE_COMB_SIN = 3'd3,
        REG_MARK_RES_COS   = 3'd4,
        REG_MARK_RES_SIN   = 3'd5,
        REG_MARK_COMB_COS  = 3'd6,
        REG_MARK_COMB_SIN  = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_16   = 2'd1,
        SH_24   = 2'd2
    } t_shift;

    typedef struct packed {
        logic   valid;
        logic   clr;
        logic   neg;
        t_shift shift;
    } t_mac_ctl;
endpackage
`default_nettype wire

// File: sv/fsk_tone_demodulator.sv
`default_nettype none
// flow: an accepted word runs the sequencer steps, then its result waits in the done state until
// the output register is free; no new word is accepted before that; 28 products per word go
// through one 32x32 multiplier, whose pipeline drains before the result is stored
// reset: synchronous active low, clears control state, filter state and registers;
// the delay line needs no clearing pass, a fill count masks unwritten entries
module fsk_tone_demodulator (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [fsk_pkg::SAMPLE_W-1:0]    i_sample,
    input  wire logic                                   i_block_start,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic                                        o_bit_res,
    output logic                                        o_carrier_present,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [fsk_pkg::PADDR_W-1:0]            paddr,
    input  wire logic [31:0]                            pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    localparam logic [4:0] STEP_LAST = 5'd29;

    t_state r_state;
    logic [4:0] r_step;
    logic signed [fsk_pkg::COEF_W-1:0] r_cfg [fsk_pkg::NUM_REGS];
    logic signed [fsk_pkg::X_W-1:0] r_x, w_old;
    logic signed [fsk_pkg::RES_W-1:0] r_s_re, r_s_im, r_m_re, r_m_im, r_tmp;
    logic signed [fsk_pkg::NRG_W-1:0] r_d, r_e1, r_e2, r_y1, r_y2, w_y;
    logic [fsk_pkg::HOLD_W-1:0] r_hold, n_hold;
    logic r_out_valid, r_bit, r_car;
    logic w_in_acc;

    fsk_pkg::t_mac_ctl w_ctl;
    logic signed [fsk_pkg::OP_W-1:0] w_a, w_b;
    logic signed [fsk_pkg::ACC_W-1:0] w_acc;

    logic w_tone;
    logic [2:0] w_sub;
    logic signed [fsk_pkg::COEF_W-1:0] w_rc, w_rs, w_cc, w_cs;
    logic signed [fsk_pkg::RES_W-1:0] w_re, w_im;
    logic signed [fsk_pkg::NRG_W:0] w_ys, w_mag;

    function automatic logic signed [fsk_pkg::RES_W-1:0] round_sat(
        input logic signed [fsk_pkg::ACC_W-1:0] a);
        logic signed [fsk_pkg::ACC_W-1:0] t;
        t = a + $signed(fsk_pkg::ACC_W'(32'd32768));
        t = t >>> 16;
        if (t[fsk_pkg::ACC_W-1:fsk_pkg::RES_W-1]
                != {(fsk_pkg::ACC_W-fsk_pkg::RES_W+1){t[fsk_pkg::ACC_W-1]}}) begin
            return t[fsk_pkg::ACC_W-1] ? {1'b1, {(fsk_pkg::RES_W-1){1'b0}}}
                                       : {1'b0, {(fsk_pkg::RES_W-1){1'b1}}};
        end
        return t[fsk_pkg::RES_W-1:0];
    endfunction

    function automatic logic signed [fsk_pkg::NRG_W-1:0] sat48(
        input logic signed [fsk_pkg::ACC_W-1:0] a);
        if (a[fsk_pkg::ACC_W-1:fsk_pkg::NRG_W-1]
                != {(fsk_pkg::ACC_W-fsk_pkg::NRG_W+1){a[fsk_pkg::ACC_W-1]}}) begin
            return a[fsk_pkg::ACC_W-1] ? {1'b1, {(fsk_pkg::NRG_W-1){1'b0}}}
                                       : {1'b0, {(fsk_pkg::NRG_W-1){1'b1}}};
        end
        return a[fsk_pkg::NRG_W-1:0];
    endfunction

    function automatic logic signed [fsk_pkg::OP_W-1:0] hi_of(
        input logic signed [fsk_pkg::NRG_W-1:0] v);
        return fsk_pkg::OP_W'($signed(v[fsk_pkg::NRG_W-1:24]));
    endfunction

    function automatic logic signed [fsk_pkg::OP_W-1:0] lo_of(
        input logic signed [fsk_pkg::NRG_W-1:0] v);
        return $signed(fsk_pkg::OP_W'(v[23:0]));
    endfunction

    fsk_delay u_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_in_acc),
        .i_clear (i_block_start),
        .i_x     ({i_sample, 1'b0}),
        .o_old   (w_old)
    );

    fsk_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_acc   (w_acc)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign pready     = 1'b1;
    assign prdata     = 32'($signed(r_cfg[paddr[fsk_pkg::PADDR_W-1:2]]));

    // operand selection per sequencer step
    always_comb begin
        w_tone = (r_step >= 5'd7);
        w_sub  = w_tone ? 3'(r_step - 5'd7) : r_step[2:0];
        w_rc = w_tone ? r_cfg[fsk_pkg::REG_MARK_RES_COS]  : r_cfg[fsk_pkg::REG_SPACE_RES_COS];
        w_rs = w_tone ? r_cfg[fsk_pkg::REG_MARK_RES_SIN]  : r_cfg[fsk_pkg::REG_SPACE_RES_SIN];
        w_cc = w_tone ? r_cfg[fsk_pkg::REG_MARK_COMB_COS] : r_cfg[fsk_pkg::REG_SPACE_COMB_COS];
        w_cs = w_tone ? r_cfg[fsk_pkg::REG_MARK_COMB_SIN] : r_cfg[fsk_pkg::REG_SPACE_COMB_SIN];
        w_re = w_tone ? r_m_re : r_s_re;
        w_im = w_tone ? r_m_im : r_s_im;
        w_ctl = '0;
        w_a   = '0;
        w_b   = '0;
        if (r_state == ST_RUN) begin
            w_ctl.valid = (r_step <= 5'd27);
            priority if (r_step <= 5'd13) begin
                unique case (w_sub)
                    3'd0: begin w_ctl.clr = 1'b1; w_a = fsk_pkg::OP_W'(r_x);
                                w_b = fsk_pkg::UNITY; end
                    3'd1: begin w_ctl.neg = 1'b1; w_a = fsk_pkg::OP_W'(w_old);
                                w_b = fsk_pkg::OP_W'(w_cc); end
                    3'd2: begin w_a = w_re; w_b = fsk_pkg::OP_W'(w_rc); end
                    3'd3: begin w_ctl.neg = 1'b1; w_a = w_im; w_b = fsk_pkg::OP_W'(w_rs); end
                    3'd4: begin w_ctl.clr = 1'b1; w_ctl.neg = 1'b1;
                                w_a = fsk_pkg::OP_W'(w_old); w_b = fsk_pkg::OP_W'(w_cs); end
                    3'd5: begin w_a = w_im; w_b = fsk_pkg::OP_W'(w_rc); end
                    3'd6: begin w_a = w_re; w_b = fsk_pkg::OP_W'(w_rs); end
                    default: ;
                endcase
            end else begin
                unique case (r_step)
                    5'd14: begin w_ctl.clr = 1'b1; w_ctl.neg = 1'b1; w_ctl.shift = fsk_pkg::SH_16;
                                 w_a = r_s_re; w_b = r_s_re; end
                    5'd15: begin w_ctl.neg = 1'b1; w_ctl.shift = fsk_pkg::SH_16;
                                 w_a = r_s_im; w_b = r_s_im; end
                    5'd16: begin w_ctl.shift = fsk_pkg::SH_16; w_a = r_m_re; w_b = r_m_re; end
                    5'd17: begin w_ctl.shift = fsk_pkg::SH_16; w_a = r_m_im; w_b = r_m_im; end
                    5'd18: begin w_ctl.clr = 1'b1; w_a = hi_of(r_e1); w_b = fsk_pkg::LP_B1; end
                    5'd19: begin w_ctl.shift = fsk_pkg::SH_24; w_a = lo_of(r_e1);
                                 w_b = fsk_pkg::LP_B1; end
                    5'd20: begin w_a = hi_of(r_e2); w_b = fsk_pkg::LP_B0; end
                    5'd21: begin w_ctl.shift = fsk_pkg::SH_24; w_a = lo_of(r_e2);
                                 w_b = fsk_pkg::LP_B0; end
                    5'd22: begin w_a = hi_of(r_y1); w_b = fsk_pkg::LP_A1; end
                    5'd23: begin w_ctl.shift = fsk_pkg::SH_24; w_a = lo_of(r_y1);
                                 w_b = fsk_pkg::LP_A1; end
                    5'd24: begin w_a = hi_of(r_y2); w_b = fsk_pkg::LP_NA2; end
                    5'd25: begin w_ctl.shift = fsk_pkg::SH_24; w_a = lo_of(r_y2);
                                 w_b = fsk_pkg::LP_NA2; end
                    5'd26: begin w_a = hi_of(r_d); w_b = fsk_pkg::LP_B0; end
                    5'd27: begin w_ctl.shift = fsk_pkg::SH_24; w_a = lo_of(r_d);
                                 w_b = fsk_pkg::LP_B0; end
                    default: ;
                endcase
            end
        end
    end

    // low-pass output and carrier hold
    always_comb begin
        w_y   = sat48(w_acc);
        w_ys  = {w_y[fsk_pkg::NRG_W-1], w_y};
        w_mag = w_ys[fsk_pkg::NRG_W] ? -w_ys : w_ys;
        priority if ($unsigned(w_mag) > fsk_pkg::HI_THRESH) begin
            n_hold = fsk_pkg::HOLD_RELOAD;
        end else if ((r_hold != '0) && ($unsigned(w_mag) < fsk_pkg::LO_THRESH)) begin
            n_hold = r_hold - 1'b1;
        end else begin
            n_hold = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fsk_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            r_cfg[paddr[fsk_pkg::PADDR_W-1:2]] <= pwdata[fsk_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_s_re      <= '0;
            r_s_im      <= '0;
            r_m_re      <= '0;
            r_m_im      <= '0;
            r_e1        <= '0;
            r_e2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_x     <= {i_sample, 1'b0};
                        r_step  <= '0;
                        r_state <= ST_RUN;
                        if (i_block_start) begin
                            r_hold <= '0;
                        end
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 1'b1;
                    unique case (r_step)
                        5'd5:  r_tmp <= round_sat(w_acc);
                        5'd8:  begin r_s_re <= r_tmp; r_s_im <= round_sat(w_acc); end
                        5'd12: r_tmp <= round_sat(w_acc);
                        5'd15: begin r_m_re <= r_tmp; r_m_im <= round_sat(w_acc); end
                        5'd19: r_d <= sat48(w_acc);
                        STEP_LAST: begin
                            r_e2    <= r_e1;
                            r_e1    <= r_d;
                            r_y2    <= r_y1;
                            r_y1    <= w_y;
                            r_hold  <= n_hold;
                            r_state <= ST_DONE;
                        end
                        default: ;
                    endcase
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_car       <= (r_hold != '0);
                        r_bit       <= (r_hold != '0) ? ~r_y1[fsk_pkg::NRG_W-1] : 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_bit_res         = r_bit;
    assign o_carrier_present = r_car;
endmodule
`default_nettype wire

// File: sv/fsk_delay.sv
`default_nettype none
module fsk_delay (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr,
    input  wire logic                            i_clear,
    input  wire logic signed [fsk_pkg::X_W-1:0]  i_x,
    output logic signed [fsk_pkg::X_W-1:0]       o_old
);
    logic signed [fsk_pkg::X_W-1:0] r_mem [fsk_pkg::DL_DEPTH];
    logic signed [fsk_pkg::X_W-1:0] r_rd;
    logic [fsk_pkg::DL_AW-1:0]      r_ptr, n_ptr, w_wp;
    logic [fsk_pkg::FILL_W-1:0]     r_fill, n_fill, w_fill;
    logic                           r_old_ok;
    logic                           w_full;

    always_comb begin
        w_wp   = i_clear ? '0 : r_ptr;
        w_fill = i_clear ? '0 : r_fill;
        w_full = (w_fill == fsk_pkg::FILL_W'(fsk_pkg::SYMBOL_SAMPLES));
        n_ptr  = (w_wp == fsk_pkg::DL_AW'(fsk_pkg::DL_DEPTH - 1)) ? '0 : w_wp + 1'b1;
        n_fill = w_full ? w_fill : w_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_fill   <= '0;
            r_old_ok <= 1'b0;
        end else if (i_wr) begin
            r_ptr    <= n_ptr;
            r_fill   <= n_fill;
            r_old_ok <= w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[w_wp] <= i_x;
            r_rd        <= r_mem[n_ptr];
        end
    end

    assign o_old = r_old_ok ? r_rd : '0;
endmodule
`default_nettype wire

// File: sv/fsk_mac.sv
`default_nettype none
module fsk_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire fsk_pkg::t_mac_ctl                 i_ctl,
    input  wire logic signed [fsk_pkg::OP_W-1:0]   i_a,
    input  wire logic signed [fsk_pkg::OP_W-1:0]   i_b,
    output logic signed [fsk_pkg::ACC_W-1:0]       o_acc
);
    logic signed [fsk_pkg::PROD_W-1:0] r_prod, w_shifted;
    logic signed [fsk_pkg::ACC_W-1:0]  r_acc, w_term;
    fsk_pkg::t_mac_ctl                 r_ctl;

    always_comb begin
        unique case (r_ctl.shift)
            fsk_pkg::SH_NONE: w_shifted = r_prod;
            fsk_pkg::SH_16:   w_shifted = r_prod >>> 16;
            fsk_pkg::SH_24:   w_shifted = r_prod >>> 24;
            default:          w_shifted = r_prod;
        endcase
        w_term = r_ctl.neg ? -w_shifted[fsk_pkg::ACC_W-1:0] : w_shifted[fsk_pkg::ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_ctl.valid) begin
            r_acc <= r_ctl.clr ? w_term : r_acc + w_term;
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire
